// ===== hw/rtl/bftrc_pkg.sv =====
// ----------------------------------------------------------------------------
// bftrc_pkg: shared types and constants for the token run coalescer
// Command byte codes, token kinds and the payload structs of both channels.
// ----------------------------------------------------------------------------
package bftrc_pkg;

    // Default width of the internal running count
    localparam int COUNT_WIDTH_DEFAULT = 16;
    // Width of the count field on the result channel
    localparam int TOKEN_COUNT_W = 16;

    // Command bytes
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;  // ']'

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_MOVE  = 3'd1,
        KIND_OUT   = 3'd2,
        KIND_IN    = 3'd3,
        KIND_OPEN  = 3'd4,
        KIND_CLOSE = 3'd5,
        KIND_NONE  = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                      token_kind;
        logic signed [TOKEN_COUNT_W-1:0] token_count;
        logic                            final_token;
    } out_item_t;

    // Decoded command byte
    typedef struct packed {
        logic  is_cmd;  // one of the eight command bytes
        kind_t kind;
        logic  folds;   // add or move: folds into a pending token of the same kind
        logic  neg;     // '-' or '<'
    } cmd_t;

    // Coalescer to top level
    typedef struct packed {
        logic      emit;
        out_item_t result;
        logic      pend_none;
    } coal_t;

endpackage

// ===== hw/rtl/bftrc_decode.sv =====
// ----------------------------------------------------------------------------
// bftrc_decode: command byte decoder
// Maps a source byte to its token kind, fold flag and step direction.
// ----------------------------------------------------------------------------
module bftrc_decode
    import bftrc_pkg::*;
(
    input  logic [7:0] character,
    output cmd_t       cmd
);

    always_comb
    begin
        cmd.is_cmd = 1'b1;
        cmd.kind   = KIND_NONE;
        cmd.folds  = 1'b0;
        cmd.neg    = 1'b0;
        unique case (character)
            CHAR_PLUS:
            begin
                cmd.kind  = KIND_ADD;
                cmd.folds = 1'b1;
            end
            CHAR_MINUS:
            begin
                cmd.kind  = KIND_ADD;
                cmd.folds = 1'b1;
                cmd.neg   = 1'b1;
            end
            CHAR_RIGHT:
            begin
                cmd.kind  = KIND_MOVE;
                cmd.folds = 1'b1;
            end
            CHAR_LEFT:
            begin
                cmd.kind  = KIND_MOVE;
                cmd.folds = 1'b1;
                cmd.neg   = 1'b1;
            end
            CHAR_DOT:   cmd.kind = KIND_OUT;
            CHAR_COMMA: cmd.kind = KIND_IN;
            CHAR_OPEN:  cmd.kind = KIND_OPEN;
            CHAR_CLOSE: cmd.kind = KIND_CLOSE;
            default:    cmd.is_cmd = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/bftrc_coalesce.sv =====
// ----------------------------------------------------------------------------
// bftrc_coalesce: pending token state and run folding
// Holds the pending token, folds add/move steps with saturation and forms
// the token to emit when a command does not fold into it or the source ends.
// ----------------------------------------------------------------------------
module bftrc_coalesce
    import bftrc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,        // item in the input register is consumed
    input  logic  end_of_source,
    input  cmd_t  cmd,
    output coal_t co
);

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    kind_t                          pend_kind_reg, pend_kind_next;
    logic signed [COUNT_WIDTH-1:0]  pend_count_reg, pend_count_next;
    logic signed [TOKEN_COUNT_W-1:0] count_out;

    // Result count is the low bits of the running count, sign-extended if narrower
    generate
        if (COUNT_WIDTH >= TOKEN_COUNT_W)
        begin : g_trunc
            assign count_out = pend_count_reg[TOKEN_COUNT_W-1:0];
        end
        else
        begin : g_sext
            assign count_out = {{(TOKEN_COUNT_W-COUNT_WIDTH){pend_count_reg[COUNT_WIDTH-1]}},
                                pend_count_reg};
        end
    endgenerate

    always_comb
    begin
        pend_kind_next            = pend_kind_reg;
        pend_count_next           = pend_count_reg;
        co.emit                   = 1'b0;
        co.result.token_kind      = pend_kind_reg;
        co.result.token_count     = count_out;
        co.result.final_token     = 1'b0;
        co.pend_none              = (pend_kind_reg == KIND_NONE);

        if (end_of_source)
        begin
            if (pend_kind_reg != KIND_NONE)
            begin
                co.emit               = 1'b1;
                co.result.final_token = 1'b1;
                pend_kind_next        = KIND_NONE;
                pend_count_next       = '0;
            end
        end
        else if (cmd.is_cmd)
        begin
            if (cmd.folds && pend_kind_reg == cmd.kind)
            begin
                // saturating +/-1
                if (cmd.neg)
                begin
                    if (pend_count_reg != CNT_MIN)
                        pend_count_next = pend_count_reg - CNT_ONE;
                end
                else
                begin
                    if (pend_count_reg != CNT_MAX)
                        pend_count_next = pend_count_reg + CNT_ONE;
                end
            end
            else
            begin
                co.emit         = (pend_kind_reg != KIND_NONE);
                pend_kind_next  = cmd.kind;
                pend_count_next = (cmd.folds && cmd.neg) ? '1 : CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_kind_reg  <= KIND_NONE;
            pend_count_reg <= '0;
        end
        else if (advance)
        begin
            pend_kind_reg  <= pend_kind_next;
            pend_count_reg <= pend_count_next;
        end
    end

endmodule

// ===== hw/rtl/bf_token_run_coalescer_top.sv =====
// ----------------------------------------------------------------------------
// bf_token_run_coalescer_top: run-length coalescing of tape-language commands
// Input register, byte decode and pending-token fold, then a result register.
// ----------------------------------------------------------------------------
// Pipeline: an item's token passes the input register, then the result register,
//   and is then valid on out_valid.
// Throughput: one item per cycle unless a token waits on out_ready; the fold
//   of +/- and >/< runs is a single compare-and-step on the pending count.
// Reset: rst_n clears both register valids and leaves no token pending.
// ----------------------------------------------------------------------------
module bf_token_run_coalescer_top
    import bftrc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT  // running count width, 8..32
)
(
    input  logic      clk,
    input  logic      rst_n,

    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,

    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // Input register: holds one accepted item until the coalescer consumes it.
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_data_reg;

    // Result register: holds one emitted token until its transfer.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    cmd_t      cmd;
    coal_t     co;
    logic      s1_advance;
    logic      out_free;

    bftrc_decode u_decode
    (
        .character (s1_data_reg.character),
        .cmd       (cmd)
    );

    bftrc_coalesce #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_coalesce
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (s1_advance),
        .end_of_source (s1_data_reg.end_of_source),
        .cmd           (cmd),
        .co            (co)
    );

    // The result register frees up in the same cycle its token transfers out.
    assign out_free = !out_valid_reg || out_ready;

    // An item that emits nothing never waits on the output side; one that
    // emits a token needs room in the result register.
    assign s1_advance = s1_valid_reg && (!co.emit || out_free);

    // A new item enters whenever the input register is empty or empties this cycle.
    assign in_ready = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance && co.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (s1_advance && co.emit)
            out_data_reg <= co.result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An end-of-source item leaves nothing pending.
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_data_reg.end_of_source) |=> co.pend_none)
        else $error("pending token survived end-of-source flush");

    // Every emitted token carries a real kind.
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.token_kind <= KIND_CLOSE))
        else $error("emitted token with no kind");

    // Non-folding tokens always count one.
    a_single_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.token_kind != KIND_ADD &&
         out_data_reg.token_kind != KIND_MOVE) |-> out_data_reg.token_count == 16'sd1)
        else $error("non-folding token with count other than one");

    // A held item stays in the input register until the coalescer takes it.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input register lost an item");

endmodule
